// File: rtl/core/triangle_affine_coordinates_assert.svh
// Assertion macros for the triangle affine-coordinate checker.
`ifndef TRIANGLE_AFFINE_COORDINATES_ASSERT_SVH
`define TRIANGLE_AFFINE_COORDINATES_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tac_pkg.sv
// Shared widths, types and saturation helpers for the triangle affine-coordinate block.
`timescale 1ns / 1ps

package tac_pkg;

  localparam int CORNER_W  = 16;
  localparam int PIX_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int EDGE_W    = 17;
  localparam int PROD_W    = 34;
  localparam int DIFF_W    = 35;
  localparam int DEN_W     = 33;
  localparam int QUO_W     = 33;
  localparam int NUM_W     = 51;
  localparam int OUT_W     = 32;
  localparam int SQ_IN_W   = 58;
  localparam int SQ_ROOT_W = 29;
  localparam int SQ_REM_W  = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C0X = 3'd0,
    REG_C0Y = 3'd1,
    REG_C1X = 3'd2,
    REG_C1Y = 3'd3,
    REG_C2X = 3'd4,
    REG_C2Y = 3'd5
  } tac_reg_t;

  // Per-triangle values produced by the setup sequencer.
  typedef struct packed {
    logic                     busy;
    logic                     degenerate;
    logic signed [EDGE_W-1:0] e1x;
    logic signed [EDGE_W-1:0] e1y;
    logic signed [EDGE_W-1:0] e2x;
    logic signed [EDGE_W-1:0] e2y;
    logic                     det_neg;
    logic [DEN_W-1:0]         det_mag;
    logic [OUT_W-1:0]         u_step_x;
    logic [OUT_W-1:0]         v_step_x;
    logic [OUT_W-1:0]         u_step_y;
    logic [OUT_W-1:0]         v_step_y;
    logic [OUT_W-1:0]         border_u;
    logic [OUT_W-1:0]         border_v;
  } tac_setup_t;

  // Applies the sign to a rounded quotient magnitude and clamps to 32 signed bits.
  function automatic logic [OUT_W-1:0] sat_signed(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic big;
    big = ovf | q[QUO_W-1] | q[OUT_W-1];
    if (neg) begin
      sat_signed = big ? {1'b1, {(OUT_W-1){1'b0}}} : (~q[OUT_W-1:0] + 32'd1);
    end else begin
      sat_signed = big ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
    end
  endfunction

  // Clamps a rounded quotient magnitude to 32 unsigned bits.
  function automatic logic [OUT_W-1:0] sat_unsigned(input logic [QUO_W-1:0] q,
                                                    input logic ovf);
    sat_unsigned = (ovf | q[QUO_W-1]) ? {OUT_W{1'b1}} : q[OUT_W-1:0];
  endfunction

endpackage

// File: rtl/core/tac_setup.sv
// Setup sequencer: edges, determinant, edge lengths and the per-triangle divisions.
`timescale 1ns / 1ps

module tac_setup (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [15:0]  c0x,
  input  logic signed [15:0]  c0y,
  input  logic signed [15:0]  c1x,
  input  logic signed [15:0]  c1y,
  input  logic signed [15:0]  c2x,
  input  logic signed [15:0]  c2y,
  output tac_pkg::tac_setup_t setup
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_EDGE    = 10'b00_0000_0010,
    ST_MUL     = 10'b00_0000_0100,
    ST_SUM     = 10'b00_0000_1000,
    ST_ABS     = 10'b00_0001_0000,
    ST_SQ_LOAD = 10'b00_0010_0000,
    ST_SQ_RUN  = 10'b00_0100_0000,
    ST_DV_LOAD = 10'b00_1000_0000,
    ST_DV_CHK  = 10'b01_0000_0000,
    ST_DV_RUN  = 10'b10_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    JOB_USX = 3'd0,
    JOB_VSX = 3'd1,
    JOB_USY = 3'd2,
    JOB_VSY = 3'd3,
    JOB_BU  = 3'd4,
    JOB_BV  = 3'd5
  } job_t;

  state_t state;
  job_t   job;

  logic signed [16:0] e1x, e1y, e2x, e2y;
  logic [16:0]        e1x_m, e1y_m, e2x_m, e2y_m;
  logic signed [33:0] m0, m1;
  logic [31:0]        q1x, q1y, q2x, q2y;
  logic signed [34:0] det;
  logic [32:0]        s1, s2;
  logic [32:0]        det_mag;
  logic               det_neg;
  logic               degen;
  logic               det_zero;

  logic [57:0]        sx;
  logic [28:0]        root;
  logic [32:0]        srem;
  logic [32:0]        sq_try, sq_trial;
  logic               sq_fit;
  logic               sq_sel;
  logic [28:0]        len_u, len_v;
  logic [5:0]         cnt;

  logic [36:0]        nmag;
  logic               nsgn;
  logic [50:0]        dv_a;
  logic [32:0]        dv_alow;
  logic [32:0]        dv_rem, dv_q, dv_q_next;
  logic [33:0]        dv_try;
  logic               dv_fit, dv_neg, dv_ovf;
  logic [31:0]        dv_res;
  logic [31:0]        r_usx, r_vsx, r_usy, r_vsy, r_bu, r_bv;

  assign e1x_m = e1x[16] ? 17'(-e1x) : 17'(e1x);
  assign e1y_m = e1y[16] ? 17'(-e1y) : 17'(e1y);
  assign e2x_m = e2x[16] ? 17'(-e2x) : 17'(e2x);
  assign e2y_m = e2y[16] ? 17'(-e2y) : 17'(e2y);

  assign det_zero = (det == 35'sd0) || (s1 == 33'd0) || (s2 == 33'd0);

  // One root digit per cycle, two radicand bits at a time.
  assign sq_try   = {srem[30:0], sx[57:56]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_fit   = sq_try >= sq_trial;

  // One quotient bit per cycle of the restoring division.
  assign dv_try    = {dv_rem, dv_alow[32]};
  assign dv_fit    = dv_try >= {1'b0, det_mag};
  assign dv_q_next = {dv_q[31:0], dv_fit};
  assign dv_res    = (job == JOB_BU || job == JOB_BV) ?
                     tac_pkg::sat_unsigned(dv_q_next, dv_ovf) :
                     tac_pkg::sat_signed(dv_q_next, dv_ovf, dv_neg);

  // Numerator magnitude and sign of the current division.
  always_comb begin
    unique case (job)
      JOB_USX: begin
        nmag = {e2y_m, 20'd0};
        nsgn = e2y[16];
      end
      JOB_VSX: begin
        nmag = {e1y_m, 20'd0};
        nsgn = !e1y[16] && (e1y != 17'sd0);
      end
      JOB_USY: begin
        nmag = {e2x_m, 20'd0};
        nsgn = !e2x[16] && (e2x != 17'sd0);
      end
      JOB_VSY: begin
        nmag = {e1x_m, 20'd0};
        nsgn = e1x[16];
      end
      JOB_BU: begin
        nmag = {len_u, 8'd0};
        nsgn = 1'b0;
      end
      JOB_BV: begin
        nmag = {len_v, 8'd0};
        nsgn = 1'b0;
      end
      default: begin
        nmag = '0;
        nsgn = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EDGE;
    end else if (start) begin
      state <= ST_EDGE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_EDGE: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_ABS;
        end
        ST_ABS: begin
          state <= det_zero ? ST_IDLE : ST_SQ_LOAD;
        end
        ST_SQ_LOAD: begin
          state <= ST_SQ_RUN;
        end
        ST_SQ_RUN: begin
          if (cnt == 6'(tac_pkg::SQ_ROOT_W - 1)) begin
            state <= sq_sel ? ST_DV_LOAD : ST_SQ_LOAD;
          end
        end
        ST_DV_LOAD: begin
          state <= ST_DV_CHK;
        end
        ST_DV_CHK: begin
          state <= ST_DV_RUN;
        end
        ST_DV_RUN: begin
          if (cnt == 6'(tac_pkg::QUO_W - 1)) begin
            state <= (job == JOB_BV) ? ST_IDLE : ST_DV_LOAD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_EDGE: begin
        e1x <= 17'(c1x) - 17'(c0x);
        e1y <= 17'(c1y) - 17'(c0y);
        e2x <= 17'(c2x) - 17'(c0x);
        e2y <= 17'(c2y) - 17'(c0y);
      end
      ST_MUL: begin
        m0  <= e1x * e2y;
        m1  <= e2x * e1y;
        q1x <= 32'(34'(e1x_m) * 34'(e1x_m));
        q1y <= 32'(34'(e1y_m) * 34'(e1y_m));
        q2x <= 32'(34'(e2x_m) * 34'(e2x_m));
        q2y <= 32'(34'(e2y_m) * 34'(e2y_m));
      end
      ST_SUM: begin
        det <= 35'(m0) - 35'(m1);
        s1  <= 33'(q1x) + 33'(q1y);
        s2  <= 33'(q2x) + 33'(q2y);
      end
      ST_ABS: begin
        det_mag <= det[34] ? 33'(-det) : 33'(det);
        det_neg <= det[34];
        degen   <= det_zero;
        sq_sel  <= 1'b0;
      end
      ST_SQ_LOAD: begin
        sx   <= {1'b0, (sq_sel ? s1 : s2), 24'd0};
        root <= '0;
        srem <= '0;
        cnt  <= '0;
      end
      ST_SQ_RUN: begin
        sx   <= {sx[55:0], 2'b00};
        srem <= sq_fit ? (sq_try - sq_trial) : sq_try;
        root <= {root[27:0], sq_fit};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'(tac_pkg::SQ_ROOT_W - 1)) begin
          if (sq_sel) begin
            len_v <= {root[27:0], sq_fit};
          end else begin
            len_u <= {root[27:0], sq_fit};
          end
          sq_sel <= 1'b1;
          job    <= JOB_USX;
        end
      end
      ST_DV_LOAD: begin
        dv_a   <= 51'(nmag) + 51'(det_mag[32:1]);
        dv_neg <= nsgn ^ det_neg;
      end
      ST_DV_CHK: begin
        dv_rem  <= 33'(dv_a[50:33]);
        dv_alow <= dv_a[32:0];
        dv_ovf  <= 33'(dv_a[50:33]) >= det_mag;
        dv_q    <= '0;
        cnt     <= '0;
      end
      ST_DV_RUN: begin
        dv_rem  <= dv_fit ? 33'(dv_try - {1'b0, det_mag}) : dv_try[32:0];
        dv_alow <= {dv_alow[31:0], 1'b0};
        dv_q    <= dv_q_next;
        cnt     <= cnt + 6'd1;
        if (cnt == 6'(tac_pkg::QUO_W - 1)) begin
          unique case (job)
            JOB_USX: r_usx <= dv_res;
            JOB_VSX: r_vsx <= dv_res;
            JOB_USY: r_usy <= dv_res;
            JOB_VSY: r_vsy <= dv_res;
            JOB_BU:  r_bu  <= dv_res;
            JOB_BV:  r_bv  <= dv_res;
            default: r_bv  <= r_bv;
          endcase
          job <= job_t'(job + 3'd1);
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  assign setup.busy       = (state != ST_IDLE);
  assign setup.degenerate = degen;
  assign setup.e1x        = e1x;
  assign setup.e1y        = e1y;
  assign setup.e2x        = e2x;
  assign setup.e2y        = e2y;
  assign setup.det_neg    = det_neg;
  assign setup.det_mag    = det_mag;
  assign setup.u_step_x   = r_usx;
  assign setup.v_step_x   = r_vsx;
  assign setup.u_step_y   = r_usy;
  assign setup.v_step_y   = r_vsy;
  assign setup.border_u   = r_bu;
  assign setup.border_v   = r_bv;

endmodule

// File: rtl/core/tac_pixel_pipe.sv
// Per-pixel pipeline: offsets, products, and a one-bit-per-stage divider for u and v.
`timescale 1ns / 1ps

module tac_pixel_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                hold,
  input  tac_pkg::tac_setup_t setup,
  input  logic signed [15:0]  c0x,
  input  logic signed [15:0]  c0y,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [11:0]  pixel_x,
  input  logic signed [11:0]  pixel_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  coord_u,
  output logic signed [31:0]  coord_v,
  output logic signed [31:0]  u_step_x,
  output logic signed [31:0]  v_step_x,
  output logic signed [31:0]  u_step_y,
  output logic signed [31:0]  v_step_y,
  output logic [31:0]         border_u,
  output logic [31:0]         border_v,
  output logic                degenerate
);

  localparam int QW      = tac_pkg::QUO_W;
  localparam int DW      = tac_pkg::DEN_W;
  localparam int NW      = tac_pkg::NUM_W;
  localparam int ST_DIV0 = 4;
  localparam int ST_OUT  = ST_DIV0 + QW;
  localparam int NSTG    = ST_OUT + 1;

  logic [NSTG-1:0] v, en;

  logic signed [16:0] e1x, e1y, e2x, e2y;
  logic [DW-1:0]      det_mag;

  logic signed [16:0] px, py;
  logic signed [33:0] pr_a, pr_b, pr_c, pr_d;
  logic signed [34:0] nu, nv;
  logic signed [34:0] ndiff [2];
  logic [34:0]        nmag  [2];
  logic [NW-1:0]      pa    [2];
  logic               pneg  [2];

  logic [DW-1:0]      rin   [QW][2];
  logic [QW-1:0]      ain   [QW][2];
  logic [QW-1:0]      qin   [QW][2];
  logic               oin   [QW][2];
  logic               nin   [QW][2];
  logic [DW:0]        trial [QW][2];
  logic               fit   [QW][2];
  logic [DW-1:0]      drem  [QW][2];
  logic [QW-1:0]      da    [QW][2];
  logic [QW-1:0]      dq    [QW][2];
  logic               dovf  [QW][2];
  logic               dneg  [QW][2];

  assign e1x     = setup.e1x;
  assign e1y     = setup.e1y;
  assign e2x     = setup.e2x;
  assign e2y     = setup.e2y;
  assign det_mag = setup.det_mag;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0] || hold;
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid && !in_stall;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign ndiff[0] = nu;
  assign ndiff[1] = nv;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nmag[l] = ndiff[l][34] ? 35'(-ndiff[l]) : 35'(ndiff[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px <= 17'($signed({pixel_x, 4'b0000})) - 17'(c0x);
      py <= 17'($signed({pixel_y, 4'b0000})) - 17'(c0y);
    end
    if (en[1]) begin
      pr_a <= e2y * px;
      pr_b <= e2x * py;
      pr_c <= e1x * py;
      pr_d <= e1y * px;
    end
    if (en[2]) begin
      nu <= 35'(pr_a) - 35'(pr_b);
      nv <= 35'(pr_c) - 35'(pr_d);
    end
    if (en[3]) begin
      for (int l = 0; l < 2; l++) begin
        pa[l]   <= NW'({nmag[l][33:0], 16'd0}) + NW'(det_mag[DW-1:1]);
        pneg[l] <= ndiff[l][34] ^ setup.det_neg;
      end
    end
  end

  // Each divider stage brings down one numerator bit and settles one quotient bit.
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < 2; l++) begin
        if (j == 0) begin
          rin[j][l] = DW'(pa[l][NW-1:QW]);
          ain[j][l] = pa[l][QW-1:0];
          qin[j][l] = '0;
          oin[j][l] = DW'(pa[l][NW-1:QW]) >= det_mag;
          nin[j][l] = pneg[l];
        end else begin
          rin[j][l] = drem[j-1][l];
          ain[j][l] = da[j-1][l];
          qin[j][l] = dq[j-1][l];
          oin[j][l] = dovf[j-1][l];
          nin[j][l] = dneg[j-1][l];
        end
        trial[j][l] = {rin[j][l], ain[j][l][QW-1]};
        fit[j][l]   = trial[j][l] >= {1'b0, det_mag};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (en[ST_DIV0+j]) begin
        for (int l = 0; l < 2; l++) begin
          drem[j][l] <= fit[j][l] ? DW'(trial[j][l] - {1'b0, det_mag}) : trial[j][l][DW-1:0];
          da[j][l]   <= {ain[j][l][QW-2:0], 1'b0};
          dq[j][l]   <= {qin[j][l][QW-2:0], fit[j][l]};
          dovf[j][l] <= oin[j][l];
          dneg[j][l] <= nin[j][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      degenerate <= setup.degenerate;
      if (setup.degenerate) begin
        coord_u  <= '0;
        coord_v  <= '0;
        u_step_x <= '0;
        v_step_x <= '0;
        u_step_y <= '0;
        v_step_y <= '0;
        border_u <= '0;
        border_v <= '0;
      end else begin
        coord_u  <= $signed(tac_pkg::sat_signed(dq[QW-1][0], dovf[QW-1][0], dneg[QW-1][0]));
        coord_v  <= $signed(tac_pkg::sat_signed(dq[QW-1][1], dovf[QW-1][1], dneg[QW-1][1]));
        u_step_x <= $signed(setup.u_step_x);
        v_step_x <= $signed(setup.v_step_x);
        u_step_y <= $signed(setup.u_step_y);
        v_step_y <= $signed(setup.v_step_y);
        border_u <= setup.border_u;
        border_v <= setup.border_v;
      end
    end
  end

endmodule

// File: rtl/core/triangle_affine_coordinates.sv
// Top level of the triangle affine-coordinate block: corner registers, setup and pixel pipeline.
// Usage: write the six corner registers (signed Q12.4) through the write port, then stream
// pixel positions; each transfer on the input returns one transfer on the output holding u, v
// relative to corner 0 (signed Q16.16, rounded to nearest with ties away from zero, saturated),
// the four per-pixel increments, the two border scales and the degenerate flag. Pixels are
// taken one per clock while in_stall is low; each passes the offset, product, difference and
// rounding stages, then the per-pixel divider, which settles one quotient bit per pipeline
// stage for u and v in parallel, and then the output stage. A stalled output only holds back
// the input once every stage is full, since empty stages keep filling. After reset and after
// every register write a setup sequencer runs with in_stall held high: it forms the edges and
// the determinant, then takes two integer square roots on one iterative unit and six divisions
// on another, or stops after the determinant when the triangle turns out degenerate. A
// degenerate triangle (a zero-length edge or a zero determinant) gives results with the
// degenerate flag set and every other field zero.
`timescale 1ns / 1ps

module triangle_affine_coordinates (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [11:0] pixel_x,
  input  logic signed [11:0] pixel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] coord_u,
  output logic signed [31:0] coord_v,
  output logic signed [31:0] u_step_x,
  output logic signed [31:0] v_step_x,
  output logic signed [31:0] u_step_y,
  output logic signed [31:0] v_step_y,
  output logic [31:0]        border_u,
  output logic [31:0]        border_v,
  output logic               degenerate
);

  // Corner registers, all Q12.4.
  logic signed [15:0] c0x, c0y, c1x, c1y, c2x, c2y;

  tac_pkg::tac_setup_t setup;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0x <= '0;
      c0y <= '0;
      c1x <= '0;
      c1y <= '0;
      c2x <= '0;
      c2y <= '0;
    end else if (cfg_write) begin
      unique case (tac_pkg::tac_reg_t'(cfg_index))
        tac_pkg::REG_C0X: c0x <= $signed(cfg_data);
        tac_pkg::REG_C0Y: c0y <= $signed(cfg_data);
        tac_pkg::REG_C1X: c1x <= $signed(cfg_data);
        tac_pkg::REG_C1Y: c1y <= $signed(cfg_data);
        tac_pkg::REG_C2X: c2x <= $signed(cfg_data);
        tac_pkg::REG_C2Y: c2y <= $signed(cfg_data);
        default: c0x <= c0x;
      endcase
    end
  end

  // Any write restarts the setup, so the per-triangle values always match the registers.
  tac_setup u_setup (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_write),
    .c0x   (c0x),
    .c0y   (c0y),
    .c1x   (c1x),
    .c1y   (c1y),
    .c2x   (c2x),
    .c2y   (c2y),
    .setup (setup)
  );

  // The pipeline refuses new pixels while setup runs or a write is in progress.
  tac_pixel_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .hold       (setup.busy || cfg_write),
    .setup      (setup),
    .c0x        (c0x),
    .c0y        (c0y),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .coord_u    (coord_u),
    .coord_v    (coord_v),
    .u_step_x   (u_step_x),
    .v_step_x   (v_step_x),
    .u_step_y   (u_step_y),
    .v_step_y   (v_step_y),
    .border_u   (border_u),
    .border_v   (border_v),
    .degenerate (degenerate)
  );

endmodule

// File: rtl/core/tac_checker.sv
// Port-level checker for the triangle affine-coordinate block and its bind.
`timescale 1ns / 1ps
`include "triangle_affine_coordinates_assert.svh"

module tac_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_write,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] coord_u,
  input logic signed [31:0] coord_v,
  input logic signed [31:0] u_step_x,
  input logic signed [31:0] v_step_x,
  input logic signed [31:0] u_step_y,
  input logic signed [31:0] v_step_y,
  input logic [31:0]        border_u,
  input logic [31:0]        border_v,
  input logic               degenerate
);

  // A degenerate triangle must clear every value field of the transfer.
  `TAC_ASSERT_SAME(a_deg_coords, out_valid && degenerate, coord_u == 32'sd0 && coord_v == 32'sd0 && u_step_x == 32'sd0 && v_step_x == 32'sd0, "degenerate result carries nonzero coordinates or x steps")
  `TAC_ASSERT_SAME(a_deg_rest, out_valid && degenerate, u_step_y == 32'sd0 && v_step_y == 32'sd0 && border_u == 32'd0 && border_v == 32'd0, "degenerate result carries nonzero y steps or borders")

  // A register write restarts setup, which must hold off pixels in the next cycle.
  `TAC_ASSERT_NEXT(a_cfg_holds_input, cfg_write, in_stall, "pixel input open right after a register write")

  // A result that is not taken stays valid, with coord_u and border_u stable.
  `TAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(coord_u) && $stable(border_u), "stalled result changed or vanished")

endmodule

bind triangle_affine_coordinates tac_checker u_tac_checker (.*);
